@@ hw/rtl/tfr_pkg.sv @@
// Package for the triangle fill rasterizer: controller states and command/status types.
// Used by tfr_ctrl, tfr_datapath and the top level; no dependencies.
`default_nettype none
package tfr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_AREA,
    ST_DIV,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_capture;
    logic load_finish;
    logic area_start;
    logic div_start;
    logic advance;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_active;
    logic covered;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/tfr_ctrl.sv @@
// Controller state machine of the triangle fill rasterizer.
// Depends on tfr_pkg for the state enum and the command/status structs.
`default_nettype none
module tfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tfr_pkg::sts_t sts_i,
  output tfr_pkg::cmd_t      cmd_o
);

  tfr_pkg::state_e state_q, state_d;
  logic acc;

  assign acc = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfr_pkg::ST_IDLE: begin
        if (acc) begin
          if (!in_kind_i) state_d = tfr_pkg::ST_LOAD;
          else if (sts_i.scan_active) state_d = tfr_pkg::ST_AREA;
        end
      end
      tfr_pkg::ST_LOAD: state_d = tfr_pkg::ST_IDLE;
      tfr_pkg::ST_AREA: state_d = sts_i.covered ? tfr_pkg::ST_DIV : tfr_pkg::ST_OUT;
      tfr_pkg::ST_DIV:  if (sts_i.div_done) state_d = tfr_pkg::ST_OUT;
      tfr_pkg::ST_OUT:  if (out_ready_i) state_d = tfr_pkg::ST_IDLE;
      default:          state_d = tfr_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == tfr_pkg::ST_IDLE);
    out_valid_o = (state_q == tfr_pkg::ST_OUT);
    case (state_q)
      tfr_pkg::ST_IDLE: begin
        cmd_o.load_capture = acc && !in_kind_i;
        cmd_o.area_start = acc && in_kind_i && sts_i.scan_active;
      end
      tfr_pkg::ST_LOAD: cmd_o.load_finish = 1'b1;
      tfr_pkg::ST_AREA: cmd_o.div_start = sts_i.covered;
      tfr_pkg::ST_OUT:  cmd_o.advance = out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tfr_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // A result is never offered while a new request is taken.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  // A step that finds an armed scan leads to the area state.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.area_start |=> state_q == tfr_pkg::ST_AREA) else $error("step lost");
  // The result stays up until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

endmodule
`default_nettype wire

@@ hw/rtl/tfr_datapath.sv @@
// Datapath of the triangle fill rasterizer: stores, scan counters, areas and divider.
// Depends on tfr_pkg for the command/status structs.
`default_nettype none
module tfr_datapath #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tfr_pkg::cmd_t                 cmd_i,
  output tfr_pkg::sts_t                      sts_o,
  input  wire logic signed [COORD_BITS-1:0]  vx_i [3],
  input  wire logic signed [COORD_BITS-1:0]  vy_i [3],
  input  wire logic [3*CHANNEL_BITS-1:0]     col_i [3],
  output logic signed [COORD_BITS-1:0]       px_o,
  output logic signed [COORD_BITS-1:0]       py_o,
  output logic                               cov_o,
  output logic [CHANNEL_BITS-1:0]            chan_o [3],
  output logic                               last_o
);

  localparam int DB = COORD_BITS + 1;     // difference width
  localparam int AB = 2 * COORD_BITS + 2; // doubled area width
  localparam int NB = AB + CHANNEL_BITS + 2; // weighted sum width
  localparam int QB = NB;
  localparam int CB = $clog2(NB + 1);

  logic signed [COORD_BITS-1:0] vx_q [3], vy_q [3];
  logic [3*CHANNEL_BITS-1:0] col_q [3];
  logic signed [COORD_BITS-1:0] xmin_q, xmax_q, ymin_q, ymax_q, x_q, y_q;
  logic [AB-1:0] whole_q, w_q [3];
  logic active_q, cov_q, busy_q;
  logic [NB-1:0] num_q [3];
  logic [NB-1:0] rem_q [3];
  logic [QB-1:0] quo_q [3];
  logic [CB-1:0] cnt_q;

  function automatic logic [AB-1:0] area2(
    input logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy);
    logic signed [AB+1:0] s;
    s = AB'(ax) * (DB'(by) - DB'(cy)) + AB'(bx) * (DB'(cy) - DB'(ay))
      + AB'(cx) * (DB'(ay) - DB'(by));
    return s[AB+1] ? AB'(-s) : AB'(s);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] mn(
    input logic signed [COORD_BITS-1:0] a, b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] mx(
    input logic signed [COORD_BITS-1:0] a, b);
    return (a > b) ? a : b;
  endfunction

  logic [AB-1:0] w_d [3];
  logic [AB+1:0] wsum;
  logic cov_d;
  logic last_d;

  // Sub-areas at the current position.
  always_comb begin
    w_d[0] = area2(x_q, y_q, vx_q[1], vy_q[1], vx_q[2], vy_q[2]);
    w_d[1] = area2(x_q, y_q, vx_q[0], vy_q[0], vx_q[2], vy_q[2]);
    w_d[2] = area2(x_q, y_q, vx_q[0], vy_q[0], vx_q[1], vy_q[1]);
    wsum = (AB+2)'(w_d[0]) + (AB+2)'(w_d[1]) + (AB+2)'(w_d[2]);
    cov_d = (whole_q != '0) && (wsum == (AB+2)'(whole_q));
    last_d = (x_q >= xmax_q) && (y_q >= ymax_q);
  end

  // Triangle stores and scan position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      xmin_q <= '0; xmax_q <= '0; ymin_q <= '0; ymax_q <= '0;
      x_q <= '0; y_q <= '0; whole_q <= '0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0; vy_q[i] <= '0; col_q[i] <= '0;
      end
    end else if (cmd_i.load_capture) begin
      active_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= vx_i[i]; vy_q[i] <= vy_i[i]; col_q[i] <= col_i[i];
      end
      xmin_q <= mn(mn(vx_i[0], vx_i[1]), vx_i[2]);
      xmax_q <= mx(mx(vx_i[0], vx_i[1]), vx_i[2]);
      ymin_q <= mn(mn(vy_i[0], vy_i[1]), vy_i[2]);
      ymax_q <= mx(mx(vy_i[0], vy_i[1]), vy_i[2]);
    end else if (cmd_i.load_finish) begin
      whole_q <= area2(vx_q[0], vy_q[0], vx_q[1], vy_q[1], vx_q[2], vy_q[2]);
      x_q <= xmin_q;
      y_q <= ymin_q;
      active_q <= 1'b1;
    end else if (cmd_i.advance) begin
      if (last_d) active_q <= 1'b0;
      else if (y_q >= ymax_q) begin
        y_q <= ymin_q;
        x_q <= x_q + COORD_BITS'(1);
      end else y_q <= y_q + COORD_BITS'(1);
    end
  end

  // Sub-areas, coverage and one-bit-per-cycle restoring divide of the three sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cov_q <= 1'b0;
      cnt_q <= '0;
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= '0;
        num_q[k] <= '0;
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (cmd_i.area_start) begin
      cov_q <= cov_d;
      for (int i = 0; i < 3; i++) w_q[i] <= w_d[i];
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q <= CB'(NB);
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= NB'(col_q[0][(2-k)*CHANNEL_BITS +: CHANNEL_BITS]) * NB'(w_q[0])
                  + NB'(col_q[1][(2-k)*CHANNEL_BITS +: CHANNEL_BITS]) * NB'(w_q[1])
                  + NB'(col_q[2][(2-k)*CHANNEL_BITS +: CHANNEL_BITS]) * NB'(w_q[2]);
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (busy_q) begin
      for (int k = 0; k < 3; k++) begin
        logic [NB:0] r;
        r = {rem_q[k], num_q[k][NB-1]};
        num_q[k] <= {num_q[k][NB-2:0], 1'b0};
        if (r >= (NB+1)'(whole_q)) begin
          rem_q[k] <= NB'(r - (NB+1)'(whole_q));
          quo_q[k] <= {quo_q[k][QB-2:0], 1'b1};
        end else begin
          rem_q[k] <= NB'(r);
          quo_q[k] <= {quo_q[k][QB-2:0], 1'b0};
        end
      end
      cnt_q <= cnt_q - CB'(1);
      if (cnt_q == CB'(1)) busy_q <= 1'b0;
    end
  end

  assign sts_o.div_done = busy_q && (cnt_q == CB'(1));
  assign sts_o.scan_active = active_q;
  assign sts_o.covered = cov_d;

  assign px_o = x_q;
  assign py_o = y_q;
  assign cov_o = cov_q;
  assign last_o = last_d;
  always_comb begin
    for (int k = 0; k < 3; k++) chan_o[k] = cov_q ? quo_q[k][CHANNEL_BITS-1:0] : '0;
  end

  // Covered implies a nonzero whole area.
  a_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.area_start && cov_d |-> whole_q != '0) else $error("zero area covered");
  // The divider only starts when idle.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !busy_q) else $error("divider restarted");
  // Advancing needs an armed scan.
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> active_q) else $error("advance with no scan");

endmodule
`default_nettype wire

@@ hw/rtl/triangle_fill_rasterizer_unit.sv @@
// Top level of the triangle fill rasterizer: stream ports around controller and datapath.
// Depends on tfr_pkg, tfr_ctrl and tfr_datapath.
//
// A load request (tuser = 0) takes three vertices and colors and gives no result.
// Each step request (tuser = 1) while a scan is armed gives the next bounding-box
// position, x outer and y inner, with a covered flag, color and tlast on the final
// position; a step with no armed scan gives no result. A covered step adds the
// restoring divide of the three channel sums, one quotient bit per cycle over
// 2*COORD_BITS+CHANNEL_BITS+4 bits (36 at the defaults); the result is held until taken.
`default_nettype none
module triangle_fill_rasterizer_unit #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tdata: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
  // color_a, color_b, color_c (from bit 0 up), zero padded to whole bytes.
  input  wire logic [((6*COORD_BITS+9*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tuser, // kind
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: pixel_x, pixel_y, covered, red, green, blue (from bit 0 up), zero padded.
  output logic [((2*COORD_BITS+1+3*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tlast
);

  localparam int OW = ((2*COORD_BITS+1+3*CHANNEL_BITS+7)/8)*8;
  localparam int CW = 3*CHANNEL_BITS;

  tfr_pkg::cmd_t cmd;
  tfr_pkg::sts_t sts;
  logic signed [COORD_BITS-1:0] vx [3], vy [3], px, py;
  logic [CW-1:0] col [3];
  logic [CHANNEL_BITS-1:0] chan [3];
  logic cov;

  // Unpack the request fields.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = s_axis_tdata[2*i*COORD_BITS +: COORD_BITS];
      vy[i] = s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
      col[i] = s_axis_tdata[6*COORD_BITS + i*CW +: CW];
    end
  end

  tfr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_kind_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  tfr_datapath #(.COORD_BITS(COORD_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .vx_i(vx), .vy_i(vy), .col_i(col),
    .px_o(px), .py_o(py), .cov_o(cov), .chan_o(chan), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = OW'({chan[2], chan[1], chan[0], cov, py, px});

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for triangle_fill_rasterizer_unit: directed and random triangles checked pixel by pixel.
// Depends on the RTL top level only; the expected pixels come from a predictor written here.
`default_nettype none
module tb_top;

  localparam int CB = 12;
  localparam int HB = 8;
  localparam int SW = ((6*CB+9*HB+7)/8)*8;
  localparam int MW = ((2*CB+1+3*HB+7)/8)*8;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic covered;
    logic [HB-1:0] red;
    logic [HB-1:0] green;
    logic [HB-1:0] blue;
    logic last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [MW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  triangle_fill_rasterizer_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // Predictor state: the loaded triangle and the scan position.
  int vert[6];
  logic [3*HB-1:0] tri_color[3];
  int box_xlo, box_xhi, box_ylo, box_yhi, col_x, row_y;
  longint tri_area;
  bit scan_on;

  pixel_t pixel_q[$];
  int errors, pixels_seen, covered_seen, loads_sent, steps_sent;
  int burst_left;
  bit hold_off;
  longint cycles;

  initial forever #2 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint twice_area(int ax, int ay, int bx, int by, int cx, int cy);
    longint s;
    s = longint'(ax) * (by - cy) + longint'(bx) * (cy - ay) + longint'(cx) * (ay - by);
    return s < 0 ? -s : s;
  endfunction

  // Work out the result, if any, that one request causes.
  task automatic predict_request(logic kind, int v[6], logic [3*HB-1:0] c[3]);
    longint w[3];
    longint s;
    pixel_t p;
    if (kind == KIND_LOAD) begin
      vert = v;
      tri_color = c;
      box_xlo = v[0]; box_xhi = v[0]; box_ylo = v[1]; box_yhi = v[1];
      for (int i = 1; i < 3; i++) begin
        if (v[2*i] < box_xlo) box_xlo = v[2*i];
        if (v[2*i] > box_xhi) box_xhi = v[2*i];
        if (v[2*i+1] < box_ylo) box_ylo = v[2*i+1];
        if (v[2*i+1] > box_yhi) box_yhi = v[2*i+1];
      end
      tri_area = twice_area(v[0], v[1], v[2], v[3], v[4], v[5]);
      col_x = box_xlo;
      row_y = box_ylo;
      scan_on = 1;
      return;
    end
    if (!scan_on) return;
    w[0] = twice_area(col_x, row_y, vert[2], vert[3], vert[4], vert[5]);
    w[1] = twice_area(col_x, row_y, vert[0], vert[1], vert[4], vert[5]);
    w[2] = twice_area(col_x, row_y, vert[0], vert[1], vert[2], vert[3]);
    p = '0;
    p.px = col_x[CB-1:0];
    p.py = row_y[CB-1:0];
    p.covered = tri_area != 0 && w[0] + w[1] + w[2] == tri_area;
    p.last = col_x >= box_xhi && row_y >= box_yhi;
    if (p.covered) begin
      s = w[0]*tri_color[0][23:16] + w[1]*tri_color[1][23:16] + w[2]*tri_color[2][23:16];
      p.red = HB'(s / tri_area);
      s = w[0]*tri_color[0][15:8] + w[1]*tri_color[1][15:8] + w[2]*tri_color[2][15:8];
      p.green = HB'(s / tri_area);
      s = w[0]*tri_color[0][7:0] + w[1]*tri_color[1][7:0] + w[2]*tri_color[2][7:0];
      p.blue = HB'(s / tri_area);
    end
    pixel_q.push_back(p);
    if (p.last) scan_on = 0;
    else if (row_y >= box_yhi) begin
      row_y = box_ylo;
      col_x++;
    end else row_y++;
  endtask

  // Send one request at the falling edge, with bursts and random gaps.
  // Within a burst tvalid stays high; it drops only for a gap or when drained.
  task automatic send_request(logic kind, int v[6], logic [3*HB-1:0] c[3]);
    logic [SW-1:0] d;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    d = '0;
    for (int i = 0; i < 6; i++) d[i*CB +: CB] = v[i][CB-1:0];
    for (int i = 0; i < 3; i++) d[6*CB + i*3*HB +: 3*HB] = c[i];
    s_axis_tdata <= d;
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(kind, v, c);
    if (kind == KIND_LOAD) loads_sent++; else steps_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_triangle(int v[6], logic [3*HB-1:0] c[3]);
    send_request(KIND_LOAD, v, c);
  endtask

  task automatic step_pixels(int n);
    int v[6];
    logic [3*HB-1:0] c[3];
    for (int i = 0; i < 6; i++) v[i] = $urandom_range(0, 4095) - 2048;
    for (int i = 0; i < 3; i++) c[i] = 24'($urandom);
    for (int i = 0; i < n; i++) send_request(KIND_STEP, v, c);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [3*HB-1:0] rand_color();
    return 24'($urandom);
  endfunction

  // Small random triangle near a random origin, so the box stays short.
  task automatic rand_small_triangle(output int v[6], input int span);
    int ox, oy;
    ox = $urandom_range(0, 4095 - span) - 2048;
    oy = $urandom_range(0, 4095 - span) - 2048;
    for (int i = 0; i < 3; i++) begin
      v[2*i] = ox + $urandom_range(0, span);
      v[2*i+1] = oy + $urandom_range(0, span);
    end
  endtask

  // Steps before any load, then extreme coordinates and colors.
  task automatic test_directed();
    int v[6];
    logic [3*HB-1:0] c[3];
    step_pixels(2);
    c = '{24'hFFFFFF, 24'h000000, 24'hFF00FF};
    v = '{-2048, -2048, -2046, -2048, -2048, -2046};
    load_triangle(v, c);
    step_pixels(9);
    step_pixels(1);
    v = '{2047, 2047, 2044, 2047, 2047, 2045};
    c = '{24'h123456, 24'hFFFFFF, 24'h00FF00};
    load_triangle(v, c);
    step_pixels(4);
    // Reload in the middle of a scan, then a zero-area line.
    v = '{0, 0, 3, 3, 1, 1};
    load_triangle(v, c);
    step_pixels(16);
    // Single point.
    v = '{5, -7, 5, -7, 5, -7};
    load_triangle(v, c);
    step_pixels(2);
  endtask

  // Mostly complete scans of small triangles, with aborted scans and stray steps.
  task automatic test_random(int budget);
    int v[6];
    logic [3*HB-1:0] c[3];
    int n, w;
    while (budget > 0) begin
      w = ($urandom_range(0, 9) == 0) ? 7 : 4;
      rand_small_triangle(v, w);
      for (int i = 0; i < 3; i++) c[i] = rand_color();
      load_triangle(v, c);
      n = (w + 1) * (w + 1);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n + 2);
      step_pixels(n);
      budget -= n + 1;
    end
  endtask

  // Long receiver hold-off while requests keep coming.
  task automatic test_backpressure();
    int v[6];
    logic [3*HB-1:0] c[3];
    v = '{-2048, 2047, 2047, 2047, 0, -2048};
    c = '{rand_color(), rand_color(), rand_color()};
    load_triangle(v, c);
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
    join_none
    step_pixels(12);
    wait_drained();
  endtask

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else if ((cycles / 500) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // Compare every accepted pixel with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      {got.blue, got.green, got.red, got.covered, got.py, got.px} = m_axis_tdata[2*CB+3*HB:0];
      got.last = m_axis_tlast;
      if (pixel_q.size() == 0) report_mismatch("unexpected pixel", got.px, 0);
      else begin
        want = pixel_q.pop_front();
        pixels_seen++;
        if (want.covered) covered_seen++;
        if (got.px != want.px) report_mismatch("pixel_x", got.px, want.px);
        if (got.py != want.py) report_mismatch("pixel_y", got.py, want.py);
        if (got.covered != want.covered) report_mismatch("covered", got.covered, want.covered);
        if (got.red != want.red) report_mismatch("red", got.red, want.red);
        if (got.green != want.green) report_mismatch("green", got.green, want.green);
        if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
      end
    end
  end

  initial begin
    scan_on = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(1300);
    wait_drained();
    $display("covered %0d loads and %0d steps, %0d pixels checked, %0d inside triangles",
             loads_sent, steps_sent, pixels_seen, covered_seen);
    if (errors == 0 && pixel_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
